// File: src/spt_pkg.sv
// Shared types and constants for the stride prefetch table.
// Used by spt_cell and stride_prefetch_table; no dependencies.
package spt_pkg;

    localparam int SPT_DEFAULT_ENTRIES = 256;
    localparam int APB_ADDR_W          = 3;

    localparam logic [31:0] MAX_PREFETCH_RESET = 32'hFFFF_FFFF;

    // register word index, taken from paddr[2]
    localparam logic REG_MAX_PREFETCH_ADDR = 1'b0;

    // confidence codes
    localparam logic [1:0] CONF_INITIAL   = 2'd0;
    localparam logic [1:0] CONF_TRANSIENT = 2'd1;
    localparam logic [1:0] CONF_STEADY    = 2'd2;
    localparam logic [1:0] CONF_NOPRED    = 2'd3;

    typedef struct packed {
        logic [31:0] access_pc;
        logic [31:0] access_addr;
    } spt_req_t;

    typedef struct packed {
        logic        prefetch_valid;
        logic [31:0] prefetch_addr;
    } spt_rsp_t;

    // lookup token walking down the chain
    typedef struct packed {
        logic        active;
        logic        hit;
        logic        pred;
        logic [31:0] pc;
        logic [31:0] addr;
        logic [31:0] cand;
    } spt_bus_t;

    // allocation broadcast from the end of the chain
    typedef struct packed {
        logic        en;
        logic [31:0] pc;
        logic [31:0] addr;
    } spt_alloc_t;

endpackage

// File: src/spt_cell.sv
// One stride table entry plus one stage of the lookup chain.
// Depends on spt_pkg.
module spt_cell
    import spt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  spt_bus_t         bus_in,
    output spt_bus_t         bus_out,
    input  spt_alloc_t       alloc,
    input  logic [IDX_W-1:0] alloc_idx
);

    logic        valid_reg;
    logic [31:0] tag_reg;
    logic [31:0] last_reg;
    logic [31:0] stride_reg;
    logic [31:0] stride_next;
    logic [1:0]  conf_reg;
    logic [1:0]  conf_next;
    logic [31:0] seen;
    logic        match;
    logic        load;
    spt_bus_t    bus_reg;
    spt_bus_t    bus_next;

    assign match = bus_in.active && !bus_in.hit && valid_reg && (tag_reg == bus_in.pc);
    assign load  = alloc.en && (alloc_idx == IDX_W'(INDEX));
    assign seen  = bus_in.addr - last_reg;

    always_comb
    begin
        stride_next = stride_reg;
        conf_next   = conf_reg;
        if (seen != stride_reg)
        begin
            case (conf_reg)
                CONF_INITIAL:
                begin
                    stride_next = seen;
                    conf_next   = CONF_TRANSIENT;
                end
                CONF_TRANSIENT:
                begin
                    stride_next = seen;
                    conf_next   = CONF_NOPRED;
                end
                CONF_STEADY:
                begin
                    conf_next   = CONF_INITIAL;   // stride kept
                end
                default:
                begin
                    stride_next = seen;
                end
            endcase
        end
        else
        begin
            conf_next = (conf_reg == CONF_NOPRED) ? CONF_TRANSIENT : CONF_STEADY;
        end
    end

    always_comb
    begin
        bus_next = bus_in;
        if (match)
        begin
            bus_next.hit  = 1'b1;
            bus_next.pred = (conf_next != CONF_NOPRED);
            bus_next.cand = bus_in.addr + stride_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            bus_reg   <= '0;
        end
        else
        begin
            bus_reg <= bus_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tag_reg    <= alloc.pc;
            last_reg   <= alloc.addr;
            stride_reg <= '0;
            conf_reg   <= CONF_INITIAL;
        end
        else if (match)
        begin
            last_reg   <= bus_in.addr;
            stride_reg <= stride_next;
            conf_reg   <= conf_next;
        end
    end

    assign bus_out = bus_reg;

endmodule

// File: src/stride_prefetch_table.sv
// Stride prefetch table top level: APB register, chain of entry cells, result stage.
// Depends on spt_pkg and spt_cell.
//
//  channel   signals                               transaction
//  --------  ------------------------------------  ---------------------------------
//  access    start, busy, req                      start high while busy low
//  result    done, rsp                             done high, one cycle, no stall
//  config    psel, penable, pwrite, paddr, pwdata   psel & penable & pwrite & pready
//            prdata, pready
//
// A lookup token walks the row of TABLE_ENTRIES cells, one cell per cycle; the
// result strobes once the token has left the last cell and passed the done
// register, busy drops in that same cycle and a new access can be taken at the
// edge that ends it.
// A miss loads the entry at the fill pointer at the edge that raises the result.
// Reset clears the valid bits and the fill pointer and sets the limit register to all ones, at once.
// The result side cannot stall; busy is the only back pressure.
module stride_prefetch_table
    import spt_pkg::*;
#(
    parameter int TABLE_ENTRIES = SPT_DEFAULT_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  spt_req_t              req,
    output logic                  done,
    output spt_rsp_t              rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [31:0]        max_addr_reg;
    logic               busy_reg;
    logic               busy_next;
    logic               done_reg;
    spt_rsp_t           rsp_reg;
    spt_rsp_t           rsp_next;
    logic [IDX_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   fill_next;
    logic               accept;
    logic               cfg_wr;
    spt_alloc_t         alloc;
    spt_bus_t           chain [0:TABLE_ENTRIES];
    spt_bus_t           tail;
    logic [TABLE_ENTRIES-1:0] active_vec;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_PREFETCH_ADDR) ? max_addr_reg : '0;

    assign accept = start && !busy_reg;

    // head token: active, no hit, no prediction, key, address, zero candidate
    assign chain[0] = {accept, 1'b0, 1'b0, req.access_pc, req.access_addr, 32'd0};

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++)
        begin : g_cell
            spt_cell #(
                .INDEX (k),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .bus_in    (chain[k]),
                .bus_out   (chain[k+1]),
                .alloc     (alloc),
                .alloc_idx (fill_reg)
            );
            assign active_vec[k] = chain[k+1].active;
        end
    endgenerate

    assign tail = chain[TABLE_ENTRIES];

    always_comb
    begin
        alloc.en   = tail.active && !tail.hit;
        alloc.pc   = tail.pc;
        alloc.addr = tail.addr;

        fill_next = fill_reg;
        if (alloc.en)
        begin
            fill_next = (fill_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : fill_reg + 1'b1;
        end

        rsp_next = '0;
        if (tail.hit && tail.pred && (tail.cand <= max_addr_reg))
        begin
            rsp_next.prefetch_valid = 1'b1;
            rsp_next.prefetch_addr  = tail.cand;
        end

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.active)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_addr_reg <= MAX_PREFETCH_RESET;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            fill_reg     <= '0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == REG_MAX_PREFETCH_ADDR))
            begin
                max_addr_reg <= pwdata;
            end
            busy_reg <= busy_next;
            done_reg <= tail.active;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail.active)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // only one lookup in flight along the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(active_vec))
        else $error("more than one lookup token in the cell row");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_no_addr_without_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.prefetch_valid) |-> (rsp.prefetch_addr == '0))
        else $error("prefetch address nonzero without a candidate");

endmodule
